// ===== sv/evring_pkg.sv =====
// Shared types, request codes and constants of the event ring.
package evring_pkg;

  localparam int QUEUE_SLOTS_DEF = 16;
  // Widest cell index for the largest supported ring of 256 slots.
  localparam int IDX_MAX_W = 8;

  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_PURGE = 2'd2;

  localparam logic [1:0] KIND_ASSOC = 2'd0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  station;
    logic [7:0]  command;
    logic [47:0] mac;
  } evring_entry_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  event_kind;
    logic [7:0]  station_id;
    logic [47:0] sta_addr;
    logic [7:0]  command_code;
    logic        purge_by_addr;
  } evring_in_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  out_kind;
    logic [7:0]  out_station;
    logic [47:0] out_mac;
    logic [7:0]  out_command;
    logic [3:0]  fill_level;
    logic [3:0]  removed_count;
  } evring_out_t;

  typedef struct packed {
    logic                 load_new;
    logic                 shift;
    logic                 keep_head;
    logic [IDX_MAX_W-1:0] sel_idx;
  } evring_ctrl_t;

endpackage

// ===== sv/evring_cell.sv =====
// One storage cell of the event chain: holds a single event.
module evring_cell
  import evring_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  evring_ctrl_t  ctrl,
  input  evring_entry_t new_entry,
  input  evring_entry_t head_entry,
  input  evring_entry_t next_entry,
  output evring_entry_t entry_q
);

  evring_entry_t entry_r;
  evring_entry_t entry_nxt;
  logic          selected;

  assign selected = (ctrl.sel_idx == IDX_MAX_W'(IDX));

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.load_new && selected) begin
      entry_nxt = new_entry;
    end else if (ctrl.shift) begin
      // A surviving head goes back in at the tail of the chain.
      entry_nxt = (ctrl.keep_head && selected) ? head_entry : next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

// ===== sv/event_ring_with_selective_purge.sv =====
// Top level of the event ring: request control, cell chain and result register.
// The ring keeps up to QUEUE_SLOTS-1 station events in a chain of cells, the
// oldest always in the first cell. A push transaction writes the cell just past
// the newest event, a pop transaction takes the first cell and moves every cell
// one place towards the head. A purge walks the held events oldest first: in
// each cycle the head is checked and the chain moves up by one; an event that
// survives is written back at the tail, so the survivors stay in order and the
// removed ones simply drop out. For push, pop and unused request codes the result
// is registered when the request is accepted, and the next request is accepted
// only once that result has been taken. A purge makes one chain step per held
// event, so its length is set by the fill level. No input is accepted while a
// result waits in the output register or a purge is under way. Slots are not
// cleared after reset; only written cells are ever read.
module event_ring_with_selective_purge
  import evring_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  evring_in_t  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output evring_out_t out_data
);

  localparam int CELLS = QUEUE_SLOTS - 1;
  localparam int CNT_W = $clog2(QUEUE_SLOTS);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PURGE = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic [CNT_W-1:0] removed_r, removed_nxt;

  // Purge key, captured when the purge transaction is accepted.
  logic [7:0]  key_sta_r;
  logic [47:0] key_mac_r;
  logic        key_by_addr_r;

  logic        out_valid_r;
  evring_out_t out_data_r;
  evring_out_t res;
  logic        out_load;

  logic          accept;
  logic          head_hit;
  evring_ctrl_t  ctrl;
  evring_entry_t new_entry;
  evring_entry_t cell_q [CELLS];

  logic [CNT_W+3:0] fill_ext;
  logic [CNT_W+3:0] removed_ext;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;

  assign new_entry.kind    = in_data.event_kind;
  assign new_entry.station = in_data.station_id;
  assign new_entry.command = in_data.command_code;
  assign new_entry.mac     = in_data.sta_addr;

  // Association events match on address only, and only when asked to;
  // every other kind matches on station id.
  assign head_hit = (cell_q[0].kind == KIND_ASSOC) ?
                    (key_by_addr_r && (cell_q[0].mac == key_mac_r)) :
                    (cell_q[0].station == key_sta_r);

  // Counts wider than four bits report their low four bits.
  assign fill_ext    = {4'b0000, count_nxt};
  assign removed_ext = {4'b0000, removed_nxt};

  genvar gi;
  generate
    for (gi = 0; gi < CELLS; gi++) begin : g_cell
      evring_entry_t next_entry;
      if (gi < CELLS - 1) begin : g_mid
        assign next_entry = cell_q[gi+1];
      end else begin : g_last
        // On a shift the last cell is fed from the head, so whatever it takes on a
        // plain shift is beyond the fill level.
        assign next_entry = cell_q[0];
      end
      evring_cell #(
        .IDX (gi)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_entry  (new_entry),
        .head_entry (cell_q[0]),
        .next_entry (next_entry),
        .entry_q    (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    steps_nxt   = steps_r;
    removed_nxt = removed_r;
    out_load    = 1'b0;
    ctrl        = '0;
    res         = '0;
    if (state_r == ST_IDLE) begin
      if (accept) begin
        unique case (in_data.req_type)
          REQ_PUSH: begin
            out_load = 1'b1;
            if (count_r != CNT_W'(CELLS)) begin
              ctrl.load_new = 1'b1;
              ctrl.sel_idx  = IDX_MAX_W'(count_r);
              count_nxt     = count_r + 1'b1;
              res.accepted  = 1'b1;
            end
          end
          REQ_POP: begin
            out_load = 1'b1;
            if (count_r != '0) begin
              ctrl.shift      = 1'b1;
              count_nxt       = count_r - 1'b1;
              res.accepted    = 1'b1;
              res.out_kind    = cell_q[0].kind;
              res.out_station = cell_q[0].station;
              res.out_command = cell_q[0].command;
              res.out_mac     = cell_q[0].mac;
            end
          end
          REQ_PURGE: begin
            if (count_r == '0) begin
              out_load     = 1'b1;
              res.accepted = 1'b1;
            end else begin
              state_nxt   = ST_PURGE;
              steps_nxt   = count_r;
              removed_nxt = '0;
            end
          end
          default: begin
            // Unused request code: answered as refused, nothing changes.
            out_load = 1'b1;
          end
        endcase
      end
    end else begin
      // One purge step: retire the head, put it back at the tail if it stays.
      ctrl.shift     = 1'b1;
      ctrl.keep_head = !head_hit;
      ctrl.sel_idx   = IDX_MAX_W'(count_r - 1'b1);
      if (head_hit) begin
        count_nxt   = count_r - 1'b1;
        removed_nxt = removed_r + 1'b1;
      end
      steps_nxt = steps_r - 1'b1;
      if (steps_r == CNT_W'(1)) begin
        state_nxt         = ST_IDLE;
        out_load          = 1'b1;
        res.accepted      = 1'b1;
        res.removed_count = removed_ext[3:0];
      end
    end
    res.fill_level = fill_ext[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      removed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      steps_r   <= steps_nxt;
      removed_r <= removed_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
    if (accept && (in_data.req_type == REQ_PURGE)) begin
      key_sta_r     <= in_data.station_id;
      key_mac_r     <= in_data.sta_addr;
      key_by_addr_r <= in_data.purge_by_addr;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/evring_checker.sv =====
// Port-level checks of the event ring and their binding to the top level.
module evring_checker
  import evring_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input evring_in_t  in_data,
  input logic        out_valid,
  input logic        out_stall,
  input evring_out_t out_data
);

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The ring works on one transaction at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while one is in flight");

  // A refused request carries no event and removes nothing.
  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |->
      out_data.removed_count == 4'd0 && out_data.out_mac == 48'd0 &&
      out_data.out_station == 8'd0 && out_data.out_command == 8'd0 &&
      out_data.out_kind == 2'd0)
    else $error("refused result carries data");

  // A purge that removed events is accepted and returns no event.
  a_purge_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.removed_count != 4'd0 |->
      out_data.accepted && out_data.out_mac == 48'd0 &&
      out_data.out_station == 8'd0 && out_data.out_command == 8'd0)
    else $error("purge result carries event data");

endmodule

bind event_ring_with_selective_purge evring_checker u_evring_checker (.*);
